>>> rtl/core/bfl_pkg.sv
package bfl_pkg;

    typedef logic [2:0]         t_action;
    typedef logic signed [23:0] t_q;

    localparam t_action ACT_START   = 3'd0;
    localparam t_action ACT_GLYPH   = 3'd1;
    localparam t_action ACT_NEWLINE = 3'd2;
    localparam t_action ACT_CR      = 3'd3;
    localparam t_action ACT_UNKNOWN = 3'd4;
    localparam t_action ACT_FINISH  = 3'd5;

    localparam logic [1:0] CFG_GLYPH_SCALE     = 2'd0;
    localparam logic [1:0] CFG_LINE_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_WIDTH_LIMIT     = 2'd2;
    localparam logic [1:0] CFG_MISSING_ADVANCE = 2'd3;

    localparam logic [15:0] GLYPH_SCALE_RST     = 16'd4096;
    localparam logic [19:0] LINE_HEIGHT_RST     = 20'd4096;
    localparam logic [19:0] WIDTH_LIMIT_RST     = 20'd0;
    localparam logic [19:0] MISSING_ADVANCE_RST = 20'd4096;

    localparam t_q Q_MAX = 24'sh7FFFFF;
    localparam t_q Q_MIN = -24'sh800000;

    typedef struct packed {
        logic [15:0] glyph_scale;
        logic [19:0] line_height;
        logic [19:0] width_limit;
        logic [19:0] missing_advance;
    } t_cfg;

    // one item after scaling: metrics already in Q16.8
    typedef struct packed {
        t_action     action;
        t_q          cw;
        t_q          ox;
        t_q          oy;
        logic [11:0] atlas_x;
        logic [11:0] atlas_y;
        logic [11:0] atlas_w;
        logic [11:0] atlas_h;
    } t_item;

    function automatic t_q sat24(input logic signed [25:0] v);
        t_q r;
        if (v > 26'sh07FFFFF) begin
            r = Q_MAX;
        end else if (v < -26'sh0800000) begin
            r = Q_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/bfl_scale.sv
module bfl_scale
    import bfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_action     i_action,
    input  logic [11:0] i_glyph_advance,
    input  logic [11:0] i_glyph_offset_x,
    input  logic [11:0] i_glyph_offset_y,
    input  logic [11:0] i_atlas_x,
    input  logic [11:0] i_atlas_y,
    input  logic [11:0] i_atlas_w,
    input  logic [11:0] i_atlas_h,
    input  logic [15:0] i_glyph_scale,
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);

    typedef struct packed {
        t_action     action;
        logic [11:0] adv;
        logic [11:0] offx;
        logic [11:0] offy;
        logic [11:0] ax;
        logic [11:0] ay;
        logic [11:0] aw;
        logic [11:0] ah;
    } t_raw;

    logic  r_v1, r_v2;
    t_raw  r_in;
    t_item r_item;
    t_item n_item;
    logic  adv2;

    // floor(v * scale / 16) saturated; arithmetic shift gives the floor
    function automatic t_q scale_units(input logic signed [12:0] v,
                                       input logic [15:0] s);
        logic signed [29:0] p;
        logic signed [29:0] q;
        p = v * $signed({1'b0, s});
        q = p >>> 4;
        return sat24(q[25:0]);
    endfunction

    assign adv2    = !r_v2 || i_ready;
    assign o_ready = !r_v1 || adv2;
    assign o_valid = r_v2;
    assign o_item  = r_item;

    always_comb begin
        n_item.action  = r_in.action;
        n_item.cw      = scale_units({1'b0, r_in.adv}, i_glyph_scale);
        n_item.ox      = scale_units({r_in.offx[11], r_in.offx}, i_glyph_scale);
        n_item.oy      = scale_units({r_in.offy[11], r_in.offy}, i_glyph_scale);
        n_item.atlas_x = r_in.ax;
        n_item.atlas_y = r_in.ay;
        n_item.atlas_w = r_in.aw;
        n_item.atlas_h = r_in.ah;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (o_ready) begin
                r_v1 <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_item <= n_item;
        end
        if (o_ready && i_valid) begin
            r_in <= '{action: i_action, adv: i_glyph_advance,
                      offx: i_glyph_offset_x, offy: i_glyph_offset_y,
                      ax: i_atlas_x, ay: i_atlas_y, aw: i_atlas_w, ah: i_atlas_h};
        end
    end

endmodule

>>> rtl/core/bfl_pen.sv
module bfl_pen
    import bfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output t_q          o_quad_x,
    output t_q          o_quad_y,
    output logic [11:0] o_rect_x,
    output logic [11:0] o_rect_y,
    output logic [11:0] o_rect_w,
    output logic [11:0] o_rect_h,
    output logic [22:0] o_label_width,
    output logic [22:0] o_label_height
);

    t_q r_pen_x, r_pen_y, r_widest;
    t_q n_pen_x, n_pen_y, n_widest;

    logic        r_ov;
    logic        r_kind;
    t_q          r_quad_x, r_quad_y;
    logic [11:0] r_rx, r_ry, r_rw, r_rh;
    logic [22:0] r_lw, r_lh;

    logic        has_res, out_free, take, wrap, end_line;
    t_q          px0, py0, wide0, wmax;
    t_q          qx, qy;
    logic [22:0] lw, lh;
    logic signed [24:0] trial;
    logic signed [25:0] hdiff;

    assign has_res  = (i_item.action == ACT_GLYPH) || (i_item.action == ACT_FINISH);
    assign out_free = !r_ov || i_ready;
    assign o_ready  = out_free || !has_res;
    assign take     = i_valid && o_ready;

    always_comb begin
        trial = 25'($signed({r_pen_x[23], r_pen_x}) + $signed({i_item.cw[23], i_item.cw}));
        wrap  = (i_item.action == ACT_GLYPH) && (i_cfg.width_limit != '0)
                && (trial > $signed({5'b0, i_cfg.width_limit}));
        end_line = wrap || (i_item.action == ACT_NEWLINE);

        px0   = end_line ? '0 : r_pen_x;
        py0   = end_line ? sat24(26'($signed({{2{r_pen_y[23]}}, r_pen_y})
                                     - $signed({6'b0, i_cfg.line_height})))
                         : r_pen_y;
        wide0 = (end_line && (r_pen_x > r_widest)) ? r_pen_x : r_widest;

        qx = sat24(26'($signed({{2{px0[23]}}, px0}) + $signed({{2{i_item.ox[23]}}, i_item.ox})));
        qy = sat24(26'($signed({{2{py0[23]}}, py0}) - $signed({{2{i_item.oy[23]}}, i_item.oy})));

        // label size; width can only saturate at the low end
        wmax = (r_pen_x > r_widest) ? r_pen_x : r_widest;
        lw   = wmax[23] ? '0 : wmax[22:0];
        hdiff = 26'($signed({6'b0, i_cfg.line_height}) - $signed({{2{r_pen_y[23]}}, r_pen_y}));
        if (hdiff[25]) begin
            lh = '0;
        end else if (hdiff > 26'sh07FFFFF) begin
            lh = 23'h7FFFFF;
        end else begin
            lh = hdiff[22:0];
        end

        n_pen_x  = r_pen_x;
        n_pen_y  = r_pen_y;
        n_widest = r_widest;
        unique case (i_item.action)
            ACT_START: begin
                n_pen_x  = '0;
                n_pen_y  = '0;
                n_widest = '0;
            end
            ACT_GLYPH: begin
                n_pen_x  = sat24(26'($signed({{2{px0[23]}}, px0})
                                     + $signed({{2{i_item.cw[23]}}, i_item.cw})));
                n_pen_y  = py0;
                n_widest = wide0;
            end
            ACT_NEWLINE: begin
                n_pen_x  = px0;
                n_pen_y  = py0;
                n_widest = wide0;
            end
            ACT_UNKNOWN: begin
                n_pen_x = sat24(26'($signed({{2{r_pen_x[23]}}, r_pen_x})
                                    + $signed({6'b0, i_cfg.missing_advance})));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x  <= '0;
            r_pen_y  <= '0;
            r_widest <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (take) begin
                r_pen_x  <= n_pen_x;
                r_pen_y  <= n_pen_y;
                r_widest <= n_widest;
            end
            if (out_free) begin
                r_ov <= take && has_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && has_res) begin
            if (i_item.action == ACT_GLYPH) begin
                r_kind   <= 1'b0;
                r_quad_x <= qx;
                r_quad_y <= qy;
                r_rx     <= i_item.atlas_x;
                r_ry     <= i_item.atlas_y;
                r_rw     <= i_item.atlas_w;
                r_rh     <= i_item.atlas_h;
                r_lw     <= '0;
                r_lh     <= '0;
            end else begin
                r_kind   <= 1'b1;
                r_quad_x <= '0;
                r_quad_y <= '0;
                r_rx     <= '0;
                r_ry     <= '0;
                r_rw     <= '0;
                r_rh     <= '0;
                r_lw     <= lw;
                r_lh     <= lh;
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_quad_x       = r_quad_x;
    assign o_quad_y       = r_quad_y;
    assign o_rect_x       = r_rx;
    assign o_rect_y       = r_ry;
    assign o_rect_w       = r_rw;
    assign o_rect_h       = r_rh;
    assign o_label_width  = r_lw;
    assign o_label_height = r_lh;

endmodule

>>> rtl/core/bitmap_font_text_layout.sv
// Channel  | Handshake                | Beat carries
// ---------+--------------------------+-------------------------------------------
// input    | i_valid / o_ready        | action, glyph metrics, atlas rectangle
// result   | o_valid / i_ready        | kind, quad position, rectangle, label size
// config   | i_cfg_valid / o_cfg_ready| register index, write data
//
// One item per cycle sustained unless a result stalls; each beat is registered in
// the input register, the scale multiply register, then the pen's result register.
// Pen state updates as each item is taken, so items follow each other with no gap.
// Synchronous active-low reset clears pen state and pipeline valids and loads config defaults.
// A stalled result holds the pipeline only for items that produce a result.
module bitmap_font_text_layout
    import bfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [11:0] i_glyph_advance,
    input  logic [11:0] i_glyph_offset_x,
    input  logic [11:0] i_glyph_offset_y,
    input  logic [11:0] i_atlas_x,
    input  logic [11:0] i_atlas_y,
    input  logic [11:0] i_atlas_w,
    input  logic [11:0] i_atlas_h,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [23:0] o_quad_x,
    output logic [23:0] o_quad_y,
    output logic [11:0] o_rect_x,
    output logic [11:0] o_rect_y,
    output logic [11:0] o_rect_w,
    output logic [11:0] o_rect_h,
    output logic [22:0] o_label_width,
    output logic [22:0] o_label_height,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item item;
    logic  item_valid, item_ready;
    t_q    quad_x, quad_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_scale     <= GLYPH_SCALE_RST;
            r_cfg.line_height     <= LINE_HEIGHT_RST;
            r_cfg.width_limit     <= WIDTH_LIMIT_RST;
            r_cfg.missing_advance <= MISSING_ADVANCE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GLYPH_SCALE:     r_cfg.glyph_scale     <= i_cfg_data[15:0];
                CFG_LINE_HEIGHT:     r_cfg.line_height     <= i_cfg_data;
                CFG_WIDTH_LIMIT:     r_cfg.width_limit     <= i_cfg_data;
                CFG_MISSING_ADVANCE: r_cfg.missing_advance <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bfl_scale u_scale (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_glyph_advance  (i_glyph_advance),
        .i_glyph_offset_x (i_glyph_offset_x),
        .i_glyph_offset_y (i_glyph_offset_y),
        .i_atlas_x        (i_atlas_x),
        .i_atlas_y        (i_atlas_y),
        .i_atlas_w        (i_atlas_w),
        .i_atlas_h        (i_atlas_h),
        .i_glyph_scale    (r_cfg.glyph_scale),
        .o_valid          (item_valid),
        .i_ready          (item_ready),
        .o_item           (item)
    );

    bfl_pen u_pen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (item_valid),
        .o_ready        (item_ready),
        .i_item         (item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_quad_x       (quad_x),
        .o_quad_y       (quad_y),
        .o_rect_x       (o_rect_x),
        .o_rect_y       (o_rect_y),
        .o_rect_w       (o_rect_w),
        .o_rect_h       (o_rect_h),
        .o_label_width  (o_label_width),
        .o_label_height (o_label_height)
    );

    assign o_quad_x = quad_x;
    assign o_quad_y = quad_y;

endmodule

>>> sim/tb.sv
module tb;
    import bfl_pkg::*;

    localparam t_action ACT_RSVD_6 = 3'd6;
    localparam t_action ACT_RSVD_7 = 3'd7;
    localparam longint LABEL_MAX = 64'd8388607;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        t_action            action;
        logic [11:0]        advance;
        logic signed [11:0] off_x;
        logic signed [11:0] off_y;
        logic [11:0]        ax;
        logic [11:0]        ay;
        logic [11:0]        aw;
        logic [11:0]        ah;
    } t_char;

    typedef struct {
        logic        kind;
        logic [23:0] quad_x;
        logic [23:0] quad_y;
        logic [11:0] rect_x;
        logic [11:0] rect_y;
        logic [11:0] rect_w;
        logic [11:0] rect_h;
        logic [22:0] label_w;
        logic [22:0] label_h;
    } t_placement;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_action;
    logic [11:0] i_glyph_advance;
    logic [11:0] i_glyph_offset_x;
    logic [11:0] i_glyph_offset_y;
    logic [11:0] i_atlas_x;
    logic [11:0] i_atlas_y;
    logic [11:0] i_atlas_w;
    logic [11:0] i_atlas_h;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [23:0] o_quad_x;
    logic [23:0] o_quad_y;
    logic [11:0] o_rect_x;
    logic [11:0] o_rect_y;
    logic [11:0] o_rect_w;
    logic [11:0] o_rect_h;
    logic [22:0] o_label_width;
    logic [22:0] o_label_height;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [19:0] i_cfg_data;

    bitmap_font_text_layout u_top (.*);

    // layout state mirrored from the block
    logic [15:0] cfg_scale   = GLYPH_SCALE_RST;
    logic [19:0] cfg_line_h  = LINE_HEIGHT_RST;
    logic [19:0] cfg_wlimit  = WIDTH_LIMIT_RST;
    logic [19:0] cfg_missing = MISSING_ADVANCE_RST;
    t_q          pen_x       = '0;
    t_q          pen_y       = '0;
    t_q          widest      = '0;

    t_placement  placements_due[$];
    int          mismatches  = 0;
    int          chars_laid  = 0;
    bit          send_steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_q clamp_q(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return t_q'(v);
    endfunction

    // font units to Q16.8: floor(v * scale / 16)
    function automatic longint font_to_pixels(longint v);
        return longint'(clamp_q((v * longint'(cfg_scale)) >>> 4));
    endfunction

    function automatic void break_line();
        if (pen_x > widest) widest = pen_x;
        pen_x = '0;
        pen_y = clamp_q(longint'(pen_y) - longint'(cfg_line_h));
    endfunction

    function automatic void lay_out_char(t_char c);
        t_placement p;
        longint     adv;
        longint     ox;
        longint     oy;
        longint     w;
        longint     h;
        p = '{default: '0};
        case (c.action)
            ACT_START: begin
                pen_x  = '0;
                pen_y  = '0;
                widest = '0;
            end
            ACT_GLYPH: begin
                adv = font_to_pixels(longint'(c.advance));
                ox  = font_to_pixels(longint'(c.off_x));
                oy  = font_to_pixels(longint'(c.off_y));
                if (cfg_wlimit != 0 && longint'(pen_x) + adv > longint'(cfg_wlimit))
                    break_line();
                p.kind   = 1'b0;
                p.quad_x = clamp_q(longint'(pen_x) + ox);
                p.quad_y = clamp_q(longint'(pen_y) - oy);
                p.rect_x = c.ax;
                p.rect_y = c.ay;
                p.rect_w = c.aw;
                p.rect_h = c.ah;
                placements_due.push_back(p);
                pen_x = clamp_q(longint'(pen_x) + adv);
            end
            ACT_NEWLINE: break_line();
            ACT_UNKNOWN: pen_x = clamp_q(longint'(pen_x) + longint'(cfg_missing));
            ACT_FINISH: begin
                w = (pen_x > widest) ? longint'(pen_x) : longint'(widest);
                h = longint'(cfg_line_h) - longint'(pen_y);
                if (w < 0) w = 0;
                if (w > LABEL_MAX) w = LABEL_MAX;
                if (h < 0) h = 0;
                if (h > LABEL_MAX) h = LABEL_MAX;
                p.kind    = 1'b1;
                p.label_w = 23'(w);
                p.label_h = 23'(h);
                placements_due.push_back(p);
            end
            default: ;  // carriage return and reserved codes
        endcase
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 60)
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n && o_valid && i_ready) begin
            if (placements_due.size() == 0) begin
                flag_mismatch("result beat with nothing pending, kind",
                              longint'(o_kind), -1);
            end else begin
                want = placements_due.pop_front();
                if (o_kind !== want.kind)
                    flag_mismatch("kind", longint'(o_kind), longint'(want.kind));
                if (o_quad_x !== want.quad_x)
                    flag_mismatch("quad_x", longint'($signed(o_quad_x)),
                                  longint'($signed(want.quad_x)));
                if (o_quad_y !== want.quad_y)
                    flag_mismatch("quad_y", longint'($signed(o_quad_y)),
                                  longint'($signed(want.quad_y)));
                if (o_rect_x !== want.rect_x)
                    flag_mismatch("rect_x", longint'(o_rect_x), longint'(want.rect_x));
                if (o_rect_y !== want.rect_y)
                    flag_mismatch("rect_y", longint'(o_rect_y), longint'(want.rect_y));
                if (o_rect_w !== want.rect_w)
                    flag_mismatch("rect_w", longint'(o_rect_w), longint'(want.rect_w));
                if (o_rect_h !== want.rect_h)
                    flag_mismatch("rect_h", longint'(o_rect_h), longint'(want.rect_h));
                if (o_label_width !== want.label_w)
                    flag_mismatch("label_width", longint'(o_label_width),
                                  longint'(want.label_w));
                if (o_label_height !== want.label_h)
                    flag_mismatch("label_height", longint'(o_label_height),
                                  longint'(want.label_h));
            end
        end
    end

    // result side backpressure
    initial begin
        int  stall_left;
        bit  take_steady;
        stall_left  = 0;
        take_steady = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
            if (stall_left > 0) begin
                stall_left--;
                i_ready = 1'b0;
            end else if (!take_steady && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(0, 2);
                i_ready = 1'b0;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    function automatic int send_gap();
        int r;
        if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
        if (send_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // called just after a falling edge; returns just after a falling edge
    // with valid still high so a following beat can go back to back
    task automatic send_char(t_char c);
        int gap;
        gap = send_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action         = c.action;
        i_glyph_advance  = c.advance;
        i_glyph_offset_x = c.off_x;
        i_glyph_offset_y = c.off_y;
        i_atlas_x        = c.ax;
        i_atlas_y        = c.ay;
        i_atlas_w        = c.aw;
        i_atlas_h        = c.ah;
        i_valid          = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        lay_out_char(c);
        if (c.action != ACT_CR && c.action <= ACT_FINISH) chars_laid++;
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_valid = 1'b0;
        while (placements_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_GLYPH_SCALE:     cfg_scale   = data[15:0];
            CFG_LINE_HEIGHT:     cfg_line_h  = data;
            CFG_WIDTH_LIMIT:     cfg_wlimit  = data;
            CFG_MISSING_ADVANCE: cfg_missing = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_char make_char(t_action a);
        t_char c;
        c.action  = a;
        c.advance = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 63))
                                                : 12'($urandom_range(0, 4095));
        c.off_x   = 12'($urandom_range(0, 4095));
        c.off_y   = 12'($urandom_range(0, 4095));
        c.ax      = 12'($urandom_range(0, 4095));
        c.ay      = 12'($urandom_range(0, 4095));
        c.aw      = 12'($urandom_range(0, 4095));
        c.ah      = 12'($urandom_range(0, 4095));
        return c;
    endfunction

    function automatic t_char glyph_char(logic [11:0] adv, logic [11:0] ox,
                                         logic [11:0] oy, logic [11:0] atl);
        t_char c;
        c = make_char(ACT_GLYPH);
        c.advance = adv;
        c.off_x   = ox;
        c.off_y   = oy;
        c.ax      = atl;
        c.ay      = atl;
        c.aw      = atl;
        c.ah      = atl;
        return c;
    endfunction

    function automatic logic [19:0] pick_reg_value(logic [1:0] idx);
        logic [19:0] v;
        int          r;
        v = 20'($urandom_range(0, 20'hFFFFF));
        r = $urandom_range(0, 9);
        case (idx)
            CFG_GLYPH_SCALE: begin
                // bits above 15 are don't-care for the scale
                if (r == 0)     v[15:0] = '0;
                else if (r == 1) v[15:0] = 16'hFFFF;
                else if (r < 6) v[15:0] = 16'($urandom_range(2048, 8192));
            end
            CFG_WIDTH_LIMIT: begin
                if (r < 2)      v = '0;
                else if (r == 2) v = 20'd1;
                else if (r == 3) v = 20'hFFFFF;
                else if (r < 7) v = 20'($urandom_range(4096, 65536));
            end
            default: begin
                if (r == 0)     v = '0;
                else if (r == 1) v = 20'hFFFFF;
                else if (r < 6) v = 20'($urandom_range(256, 8192));
            end
        endcase
        return v;
    endfunction

    // defaults after reset: unit scale, no wrapping
    task automatic test_reset_defaults();
        send_char(make_char(ACT_START));
        send_char(glyph_char(12'hFFF, 12'h7FF, 12'h800, 12'hFFF));
        send_char(glyph_char(12'h000, 12'h800, 12'h7FF, 12'h000));
        send_char(make_char(ACT_CR));
        send_char(make_char(ACT_UNKNOWN));
        send_char(make_char(ACT_RSVD_6));
        send_char(make_char(ACT_RSVD_7));
        send_char(make_char(ACT_NEWLINE));
        send_char(make_char(ACT_FINISH));
        send_char(make_char(ACT_FINISH));
        wait_idle();
    endtask

    // tiny width limit wraps every glyph; large sizes drive the pen into saturation
    task automatic test_wrap_saturation();
        int k;
        write_reg(CFG_GLYPH_SCALE, 20'hAFFFF);
        write_reg(CFG_LINE_HEIGHT, 20'hFFFFF);
        write_reg(CFG_WIDTH_LIMIT, 20'd1);
        write_reg(CFG_MISSING_ADVANCE, 20'hFFFFF);
        send_char(make_char(ACT_START));
        for (k = 0; k < 9; k++) begin
            if (k[0]) send_char(glyph_char(12'hFFF, 12'h800, 12'h800, 12'(k)));
            else      send_char(glyph_char(12'hFFF, 12'h7FF, 12'h7FF, 12'(k)));
        end
        send_char(make_char(ACT_UNKNOWN));
        send_char(make_char(ACT_FINISH));
        wait_idle();
    endtask

    task automatic test_zero_scale();
        write_reg(CFG_GLYPH_SCALE, 20'd0);
        write_reg(CFG_LINE_HEIGHT, 20'd0);
        write_reg(CFG_WIDTH_LIMIT, 20'hFFFFF);
        write_reg(CFG_MISSING_ADVANCE, 20'd0);
        send_char(make_char(ACT_START));
        send_char(make_char(ACT_GLYPH));
        send_char(make_char(ACT_UNKNOWN));
        send_char(make_char(ACT_NEWLINE));
        send_char(make_char(ACT_FINISH));
        wait_idle();
    endtask

    // mostly start ... finish runs; some runs broken, some beats noise
    task automatic send_paragraph();
        int n;
        int r;
        n = $urandom_range(1, 40);
        if ($urandom_range(0, 9) != 0) send_char(make_char(ACT_START));
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 65)      send_char(make_char(ACT_GLYPH));
            else if (r < 77) send_char(make_char(ACT_UNKNOWN));
            else if (r < 89) send_char(make_char(ACT_NEWLINE));
            else if (r < 94) send_char(make_char(ACT_CR));
            else             send_char(make_char(t_action'($urandom_range(0, 7))));
        end
        if ($urandom_range(0, 9) != 0) send_char(make_char(ACT_FINISH));
        if ($urandom_range(0, 7) == 0) send_char(make_char(ACT_FINISH));
    endtask

    task automatic test_random_text();
        int phase;
        int quota;
        for (phase = 0; phase < 7; phase++) begin
            wait_idle();
            write_reg(CFG_GLYPH_SCALE, pick_reg_value(CFG_GLYPH_SCALE));
            write_reg(CFG_LINE_HEIGHT, pick_reg_value(CFG_LINE_HEIGHT));
            write_reg(CFG_WIDTH_LIMIT, pick_reg_value(CFG_WIDTH_LIMIT));
            write_reg(CFG_MISSING_ADVANCE, pick_reg_value(CFG_MISSING_ADVANCE));
            quota = chars_laid + 80;
            while (chars_laid < quota) begin
                send_paragraph();
                if ($urandom_range(0, 5) == 0) wait_results_drained();
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_action         = ACT_START;
        i_glyph_advance  = '0;
        i_glyph_offset_x = '0;
        i_glyph_offset_y = '0;
        i_atlas_x        = '0;
        i_atlas_y        = '0;
        i_atlas_w        = '0;
        i_atlas_h        = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_GLYPH_SCALE;
        i_cfg_data       = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_wrap_saturation();
        test_zero_scale();
        test_random_text();
        wait_idle();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bfl_pkg.sv
rtl/core/bfl_scale.sv
rtl/core/bfl_pen.sv
rtl/core/bitmap_font_text_layout.sv
sim/tb.sv
